### sv/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define AST_CLK_RST(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define AST_CLK(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/fali_pkg.sv
package fali_pkg;

    // axis count and index width
    localparam int AXES   = 4;
    localparam int AXIS_W = $clog2(AXES);

    // angle limits in degrees
    localparam logic [7:0] NEUTRAL_ANGLE = 8'd90;
    localparam logic [7:0] MAX_ANGLE     = 8'd180;

    // item modes
    localparam logic MODE_MOVE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // quotient bits produced by the shared divider
    localparam int DIV_STEPS = 8;
    localparam int BIT_W     = $clog2(DIV_STEPS);

    typedef logic [7:0] t_angle;

    // clamp a target to the servo range
    function automatic t_angle sat_angle(input logic [7:0] t);
        sat_angle = (t > MAX_ANGLE) ? MAX_ANGLE : t;
    endfunction

endpackage

### sv/fali_if.sv
// command channel: move or tick items
interface fali_cmd_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] target_a;
    logic [7:0] target_b;
    logic [7:0] target_c;
    logic [7:0] target_d;

    modport source (output valid, output mode, output target_a, output target_b,
                    output target_c, output target_d, input ready);
    modport sink   (input valid, input mode, input target_a, input target_b,
                    input target_c, input target_d, output ready);
endinterface

// position channel: one set of commanded angles per item
interface fali_pos_if;
    logic       valid;
    logic       ready;
    logic [7:0] angle_a;
    logic [7:0] angle_b;
    logic [7:0] angle_c;
    logic [7:0] angle_d;
    logic       last_step;

    modport source (output valid, output angle_a, output angle_b, output angle_c,
                    output angle_d, output last_step, input ready);
    modport sink   (input valid, input angle_a, input angle_b, input angle_c,
                    input angle_d, input last_step, output ready);
endinterface

### sv/four_axis_linear_interpolator_top.sv
// channel  | dir | payload                                | transfer when
// i_cmd    | in  | mode, target_a..target_d               | valid & ready
// o_pos    | out | angle_a..angle_d, last_step            | valid & ready
//
// a move item runs each axis in turn through the shared distance compare
// a moving tick runs each axis in turn: each axis uses the shared multiplier twice
//   and the shared restoring divider for 8 steps
// an idle tick goes straight to the output state; i_cmd is not ready until the result sits in the output register
// o_pos holds its result under stall; a new command is taken while it waits
// reset is synchronous: all angles return to 90 and the block is idle
`include "assert_macros.svh"

module four_axis_linear_interpolator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fali_cmd_if.sink  i_cmd,
    fali_pos_if.source o_pos
);
    import fali_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_MUL0 = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state;
    logic [AXIS_W-1:0] r_axis;
    logic [BIT_W-1:0]  r_bit;
    t_angle            r_present [AXES];
    t_angle            r_start   [AXES];
    t_angle            r_goal    [AXES];
    logic [7:0]        r_index;
    logic [7:0]        r_total;
    logic              r_moving;
    logic              r_last;
    logic [7:0]        r_most;
    logic [14:0]       r_prod;
    logic [7:0]        r_rem;
    logic [7:0]        r_quo;

    logic              r_out_valid;
    t_angle            r_out_angle [AXES];
    logic              r_out_last;

    t_angle            w_target [AXES];
    t_angle            w_cur_start;
    t_angle            w_cur_goal;
    logic [7:0]        w_dist;
    logic [7:0]        n_most;
    t_angle            w_mul_a;
    logic [7:0]        w_mul_b;
    logic [15:0]       w_prod;
    logic [15:0]       w_sum;
    logic [14:0]       w_num;
    logic [8:0]        w_shift;
    logic [8:0]        w_sub;
    logic              w_ge;
    logic              w_last_axis;
    logic              w_load_out;

    // targets as an array
    assign w_target[0] = i_cmd.target_a;
    assign w_target[1] = i_cmd.target_b;
    assign w_target[2] = i_cmd.target_c;
    assign w_target[3] = i_cmd.target_d;

    assign i_cmd.ready = (r_state == S_IDLE);

    // per-axis operands of the current step
    assign w_cur_start = r_start[r_axis];
    assign w_cur_goal  = r_goal[r_axis];
    assign w_last_axis = (r_axis == AXIS_W'(AXES - 1));

    // shared distance compare for the step count
    assign w_dist = (w_cur_goal >= w_cur_start) ? (w_cur_goal - w_cur_start)
                                                : (w_cur_start - w_cur_goal);
    assign n_most = (w_dist > r_most) ? w_dist : r_most;

    // shared multiplier: start * (total - index), then goal * index
    assign w_mul_a = (r_state == S_MUL0) ? w_cur_start : w_cur_goal;
    assign w_mul_b = (r_state == S_MUL0) ? (r_total - r_index) : r_index;
    assign w_prod  = w_mul_a * w_mul_b;
    assign w_sum   = {1'b0, r_prod} + {1'b0, w_prod[14:0]};
    assign w_num   = w_sum[14:0];

    // shared restoring divider step, divisor is the step count
    assign w_shift = {r_rem, r_quo[7]};
    assign w_ge    = (w_shift >= {1'b0, r_total});
    assign w_sub   = w_shift - {1'b0, r_total};

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || o_pos.ready);

    // sequencer and interpolation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_bit    <= '0;
            r_index  <= '0;
            r_total  <= '0;
            r_moving <= 1'b0;
            r_last   <= 1'b1;
            for (int a = 0; a < AXES; a++) begin
                r_present[a] <= NEUTRAL_ANGLE;
                r_start[a]   <= NEUTRAL_ANGLE;
                r_goal[a]    <= NEUTRAL_ANGLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_axis <= '0;
                        if (i_cmd.mode == MODE_MOVE) begin
                            for (int a = 0; a < AXES; a++) begin
                                r_start[a] <= r_present[a];
                                r_goal[a]  <= sat_angle(w_target[a]);
                            end
                            r_most  <= '0;
                            r_state <= S_MOVE;
                        end else if (!r_moving) begin
                            r_last  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_index <= r_index + 8'd1;
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_MOVE: begin
                    r_most <= n_most;
                    if (w_last_axis) begin
                        r_total  <= n_most;
                        r_index  <= '0;
                        r_moving <= (n_most != 8'd0);
                        r_last   <= (n_most == 8'd0);
                        r_state  <= S_OUT;
                    end else begin
                        r_axis <= r_axis + AXIS_W'(1);
                    end
                end
                S_MUL0: begin
                    r_prod  <= w_prod[14:0];
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_rem   <= {1'b0, w_num[14:8]};
                    r_quo   <= w_num[7:0];
                    r_bit   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_sub[7:0] : w_shift[7:0];
                    r_quo <= {r_quo[6:0], w_ge};
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(DIV_STEPS - 1)) begin
                        r_present[r_axis] <= {r_quo[6:0], w_ge};
                        if (w_last_axis) begin
                            r_moving <= (r_index < r_total);
                            r_last   <= (r_index >= r_total);
                            r_state  <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + AXIS_W'(1);
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_pos.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            for (int a = 0; a < AXES; a++) begin
                r_out_angle[a] <= r_present[a];
            end
            r_out_last <= r_last;
        end
    end

    assign o_pos.valid     = r_out_valid;
    assign o_pos.angle_a   = r_out_angle[0];
    assign o_pos.angle_b   = r_out_angle[1];
    assign o_pos.angle_c   = r_out_angle[2];
    assign o_pos.angle_d   = r_out_angle[3];
    assign o_pos.last_step = r_out_last;

    // divider remainder stays below the divisor
    `AST_CLK_RST(a_rem_below_total, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (r_rem < r_total), "divider remainder out of range")

    // a running move never passes its step count, the final step reaches it
    `AST_CLK_RST(a_index_in_move, i_clk, i_rst_n,
        r_moving |-> (r_index <= r_total), "step index passed count while moving")

    // every commanded angle stays in servo range
    `AST_CLK_RST(a_angle_range, i_clk, i_rst_n,
        o_pos.valid |-> ((o_pos.angle_a <= MAX_ANGLE) && (o_pos.angle_b <= MAX_ANGLE) &&
                         (o_pos.angle_c <= MAX_ANGLE) && (o_pos.angle_d <= MAX_ANGLE)),
        "angle above servo range")

    // a finished result waits while the output is stalled
    `AST_CLK_RST(a_out_wait, i_clk, i_rst_n,
        ((r_state == S_OUT) && r_out_valid && !o_pos.ready) |=> (r_state == S_OUT),
        "result dropped under output stall")

endmodule

### test/four_axis_linear_interpolator_top_tb.sv
`timescale 1ns / 100ps

module four_axis_linear_interpolator_top_tb;
    import fali_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_ROWS     = 17;

    typedef struct packed {
        logic   mode;
        t_angle tgt_a;
        t_angle tgt_b;
        t_angle tgt_c;
        t_angle tgt_d;
    } cmd_t;

    typedef struct packed {
        t_angle ang_a;
        t_angle ang_b;
        t_angle ang_c;
        t_angle ang_d;
        logic   last;
    } pos_t;

    typedef struct packed {
        cmd_t cmd;
        logic typed;
        pos_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    fali_cmd_if cmd_if ();
    fali_pos_if pos_if ();

    four_axis_linear_interpolator_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_pos   (pos_if)
    );

    // predictor state
    t_angle     cur_ang  [AXES];
    t_angle     org_ang  [AXES];
    t_angle     goal_ang [AXES];
    logic [7:0] step_no;
    logic [7:0] step_cnt;
    logic       in_motion;

    pos_t expected_angles_q [$];
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;
    int   sent_cnt     = 0;
    int   send_gap_pct = 0;
    int   recv_stall_pct = 0;

    // side info riding along with the command under transfer
    logic cur_typed;
    pos_t cur_want;

    dir_row_t dir_rows [NUM_ROWS];

    always #5 clk = ~clk;

    // advance the servo model by one command and return the angles it emits
    function automatic pos_t advance_servos(input cmd_t c);
        t_angle tgt [AXES];
        int     t;
        int     span;
        int     most;
        int     delta;
        int     num;
        int     v;
        pos_t   r;
        tgt[0] = c.tgt_a;
        tgt[1] = c.tgt_b;
        tgt[2] = c.tgt_c;
        tgt[3] = c.tgt_d;
        if (c.mode == MODE_MOVE) begin
            most = 0;
            for (int i = 0; i < AXES; i++) begin
                t = (int'(tgt[i]) > int'(MAX_ANGLE)) ? int'(MAX_ANGLE) : int'(tgt[i]);
                org_ang[i]  = cur_ang[i];
                goal_ang[i] = t_angle'(t);
                span = t - int'(cur_ang[i]);
                if (span < 0) span = -span;
                if (span > most) most = span;
            end
            step_cnt  = most[7:0];
            step_no   = 8'd0;
            in_motion = (most != 0);
        end else if (in_motion) begin
            step_no = step_no + 8'd1;
            for (int i = 0; i < AXES; i++) begin
                delta = int'(goal_ang[i]) - int'(org_ang[i]);
                num   = delta * int'(step_no);
                // floor toward minus infinity for negative spans
                if (num >= 0)
                    v = int'(org_ang[i]) + num / int'(step_cnt);
                else
                    v = int'(org_ang[i]) - ((-num + int'(step_cnt) - 1) / int'(step_cnt));
                if (v < 0) v = 0;
                if (v > int'(MAX_ANGLE)) v = int'(MAX_ANGLE);
                cur_ang[i] = t_angle'(v);
            end
            if (step_no >= step_cnt) in_motion = 1'b0;
        end
        r.ang_a = cur_ang[0];
        r.ang_b = cur_ang[1];
        r.ang_c = cur_ang[2];
        r.ang_d = cur_ang[3];
        r.last  = !in_motion;
        return r;
    endfunction

    // scoreboard: check results first, then queue the new expectation
    always @(posedge clk) begin
        pos_t got;
        pos_t want;
        pos_t pred;
        if (rst_n) begin
            if (pos_if.valid && pos_if.ready) begin
                got = {pos_if.angle_a, pos_if.angle_b, pos_if.angle_c, pos_if.angle_d,
                       pos_if.last_step};
                if (expected_angles_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected position transfer: %0d %0d %0d %0d last %0b",
                                 got.ang_a, got.ang_b, got.ang_c, got.ang_d, got.last);
                    mismatch_cnt++;
                end else begin
                    want = expected_angles_q.pop_front();
                    if (got.ang_a !== want.ang_a || got.ang_b !== want.ang_b ||
                        got.ang_c !== want.ang_c || got.ang_d !== want.ang_d ||
                        got.last !== want.last) begin
                        if (mismatch_cnt < 10)
                            $display("position mismatch: exp %0d %0d %0d %0d last %0b, got %0d %0d %0d %0d last %0b",
                                     want.ang_a, want.ang_b, want.ang_c, want.ang_d, want.last,
                                     got.ang_a, got.ang_b, got.ang_c, got.ang_d, got.last);
                        mismatch_cnt++;
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                pred = advance_servos({cmd_if.mode, cmd_if.target_a, cmd_if.target_b,
                                       cmd_if.target_c, cmd_if.target_d});
                expected_angles_q.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    // receiver stalls
    always @(negedge clk) begin
        pos_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one command transfer, starting and ending at a falling edge
    task automatic drive_cmd(input cmd_t c, input logic typed, input pos_t want);
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.mode     <= c.mode;
        cmd_if.target_a <= c.tgt_a;
        cmd_if.target_b <= c.tgt_b;
        cmd_if.target_c <= c.tgt_c;
        cmd_if.target_d <= c.tgt_d;
        cur_typed       <= typed;
        cur_want        <= want;
        do @(posedge clk); while (!cmd_if.ready);
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic pick_phase(input int phase);
        case (phase)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 67; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 67; end
            default: begin send_gap_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    initial begin
        cmd_t c;
        int   plan_pos [AXES];
        int   t_new    [AXES];
        int   roll;
        int   span;
        int   most;
        int   ticks;
        int   n;

        rst_n           = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.mode     = MODE_MOVE;
        cmd_if.target_a = 8'd0;
        cmd_if.target_b = 8'd0;
        cmd_if.target_c = 8'd0;
        cmd_if.target_d = 8'd0;
        pos_if.ready    = 1'b0;
        cur_typed       = 1'b0;
        cur_want        = '0;
        for (int i = 0; i < AXES; i++) begin
            cur_ang[i]  = NEUTRAL_ANGLE;
            org_ang[i]  = NEUTRAL_ANGLE;
            goal_ang[i] = NEUTRAL_ANGLE;
            plan_pos[i] = 90;
        end
        step_no   = 8'd0;
        step_cnt  = 8'd0;
        in_motion = 1'b0;

        // directed rows: idle ticks, zero-length move, one-step move, saturation,
        // restart mid-move, full-range moves in both directions
        dir_rows = '{
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 1'b1}},
            '{'{MODE_TICK, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 1'b1}},
            '{'{MODE_MOVE, 8'd90,  8'd90,  8'd90,  8'd90},  1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 1'b1}},
            '{'{MODE_MOVE, 8'd91,  8'd90,  8'd89,  8'd90},  1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 1'b0}},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_MOVE, 8'd255, 8'd0,   8'd200, 8'd181}, 1'b0, '0},
            '{'{MODE_TICK, 8'd17,  8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_MOVE, 8'd0,   8'd180, 8'd0,   8'd180}, 1'b0, '0},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_MOVE, 8'd180, 8'd180, 8'd180, 8'd180}, 1'b0, '0},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_MOVE, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
            '{'{MODE_TICK, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            drive_cmd(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].want);

        // random part: mostly complete moves, some aborted, some noise
        sent_cnt = 0;
        while (sent_cnt < RANDOM_ITEMS) begin
            pick_phase((sent_cnt / 120) % 4);
            roll = $urandom_range(99);
            if (roll < 10) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    c = {1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom)};
                    drive_cmd(c, 1'b0, '0);
                end
            end else begin
                most = 0;
                for (int i = 0; i < AXES; i++) begin
                    if (roll < 18)
                        t_new[i] = $urandom_range(0, 255);
                    else if (roll >= 95)
                        t_new[i] = plan_pos[i];
                    else begin
                        t_new[i] = plan_pos[i] + $urandom_range(0, 24) - 12;
                        if (t_new[i] < 0) t_new[i] = 0;
                        if (t_new[i] > 180) t_new[i] = 180;
                    end
                    if (t_new[i] > 180) span = 180 - plan_pos[i];
                    else span = t_new[i] - plan_pos[i];
                    if (span < 0) span = -span;
                    if (span > most) most = span;
                end
                c = {MODE_MOVE, 8'(t_new[0]), 8'(t_new[1]), 8'(t_new[2]), 8'(t_new[3])};
                drive_cmd(c, 1'b0, '0);
                ticks = most;
                if ($urandom_range(99) < 15)
                    ticks = $urandom_range(0, most);
                else if ($urandom_range(99) < 20)
                    ticks = most + $urandom_range(1, 3);
                repeat (ticks) begin
                    c = {MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
                    drive_cmd(c, 1'b0, '0);
                end
                for (int i = 0; i < AXES; i++)
                    plan_pos[i] = (t_new[i] > 180) ? 180 : t_new[i];
            end
        end
        cmd_if.valid <= 1'b0;

        // drain outstanding positions, then watch for strays
        pick_phase(0);
        while (expected_angles_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/fali_pkg.sv
sv/fali_if.sv
sv/four_axis_linear_interpolator_top.sv
test/four_axis_linear_interpolator_top_tb.sv
